// ===== src/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Types, codes and defaults shared by the ring deque message queue and its
// slot cells.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W     = 2;
	localparam int MSG_W    = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int CAP_W    = 5;

	localparam int CAPACITY_RESET = 16;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND     = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP        = 2'd2
	} op_t;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WAIT    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [MSG_W-1:0] message_in;
		logic             wait_if_blocked;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MSG_W-1:0]    message_out;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	// what a slot cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT_BACK,
		CELL_SHIFT_FWD,
		CELL_APPEND
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       sel;
	} cell_ctrl_t;

endpackage

// ===== src/rdq_cell.sv =====
// ----------------------------------------------------------------------------
// rdq_cell
// One message slot of the deque row: holds its word, takes the word of the
// neighbour nearer the head or nearer the tail, or loads a new message.
// ----------------------------------------------------------------------------
module rdq_cell #(
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  rdq_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] new_msg,
	input  logic [DATA_WIDTH-1:0] from_front,
	input  logic [DATA_WIDTH-1:0] from_back,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.mode)
			rdq_pkg::CELL_HOLD: begin
				data_q <= data_q;
			end
			rdq_pkg::CELL_SHIFT_BACK: begin
				data_q <= from_front;
			end
			rdq_pkg::CELL_SHIFT_FWD: begin
				data_q <= from_back;
			end
			rdq_pkg::CELL_APPEND: begin
				if (ctrl.sel) begin
					data_q <= new_msg;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== src/ring_deque_message_queue.sv =====
// ----------------------------------------------------------------------------
// ring_deque_message_queue
// Message deque: append at the tail, push before the head, pop from the head,
// with a programmable number of slots in use.
// ----------------------------------------------------------------------------
// One request beat is taken per cycle and gives one response beat in the next
// cycle from a single response register; a new request is taken whenever that
// register is empty or is being read in the same cycle. The messages sit in a
// row of DEPTH slot cells with the head always in cell 0: a push-front moves
// every cell one place back, a pop moves every cell one place forward, and an
// append loads the cell at the fill count. Appends and push-fronts on a full
// queue and pops on an empty one change nothing and answer refused, or must
// wait when the caller asked to wait. Capacity writes of 0 count as 1, writes
// above DEPTH as DEPTH, and writes while messages are held are ignored.
module ring_deque_message_queue #(
	parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rdq_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rdq_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [rdq_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int CAP_RESET_VAL =
		(DEPTH < rdq_pkg::CAPACITY_RESET) ? DEPTH : rdq_pkg::CAPACITY_RESET;

	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         fill_d;
	logic [CW-1:0]         capacity_q;
	logic                  rsp_valid_q;
	rdq_pkg::rsp_t         rsp_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	rdq_pkg::cell_mode_t   mode;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] popped;
	logic [DATA_WIDTH-1:0] new_msg;
	logic [63:0]           msg_wide;
	logic [63:0]           pop_wide;
	logic [31:0]           fill_wide;
	logic [CW-1:0]         cap_new;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = fill_q >= capacity_q;
	assign empty     = fill_q == '0;

	assign msg_wide = 64'(req.message_in);
	assign new_msg  = msg_wide[DATA_WIDTH-1:0];

	always_comb begin
		mode   = rdq_pkg::CELL_HOLD;
		fill_d = fill_q;
		status = rdq_pkg::ST_DONE;
		popped = '0;
		unique case (req.op)
			rdq_pkg::OP_APPEND, rdq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status = req.wait_if_blocked ? rdq_pkg::ST_WAIT : rdq_pkg::ST_REFUSED;
				end else begin
					mode   = (req.op == rdq_pkg::OP_APPEND) ? rdq_pkg::CELL_APPEND
						: rdq_pkg::CELL_SHIFT_BACK;
					fill_d = fill_q + CW'(1);
				end
			end
			rdq_pkg::OP_POP: begin
				if (empty) begin
					status = req.wait_if_blocked ? rdq_pkg::ST_WAIT : rdq_pkg::ST_REFUSED;
				end else begin
					mode   = rdq_pkg::CELL_SHIFT_FWD;
					fill_d = fill_q - CW'(1);
					popped = cell_data[0];
				end
			end
			default: begin
				status = rdq_pkg::ST_REFUSED;
			end
		endcase
	end

	assign pop_wide  = 64'(popped);
	assign fill_wide = 32'(fill_d);

	// slot row, head in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rdq_pkg::cell_ctrl_t   ctrl;
		logic [DATA_WIDTH-1:0] from_front;
		logic [DATA_WIDTH-1:0] from_back;

		assign ctrl.mode = accept ? mode : rdq_pkg::CELL_HOLD;
		assign ctrl.sel  = fill_q == CW'(i);

		if (i == 0) begin : g_first
			assign from_front = new_msg;
		end else begin : g_mid
			assign from_front = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign from_back = cell_data[i];
		end else begin : g_rest
			assign from_back = cell_data[i+1];
		end

		rdq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_msg    (new_msg),
			.from_front (from_front),
			.from_back  (from_back),
			.data       (cell_data[i])
		);
	end

	// capacity clamped to 1..DEPTH
	always_comb begin
		priority if (cfg_wdata == '0) begin
			cap_new = CW'(1);
		end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			capacity_q  <= CW'(CAP_RESET_VAL);
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
			end
			if (cfg_we && empty) begin
				capacity_q <= cap_new;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status;
			rsp_q.message_out <= pop_wide[31:0];
			rsp_q.occupancy   <= fill_wide[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_within_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= capacity_q)
		else $error("fill count above capacity");

	a_capacity_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		capacity_q != '0)
		else $error("capacity reached zero");

	a_pop_drops_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == rdq_pkg::OP_POP && !empty |=> fill_q == $past(fill_q) - CW'(1))
		else $error("pop did not lower the fill count");

	a_blocked_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status != rdq_pkg::ST_DONE |=> $stable(fill_q))
		else $error("refused beat changed the fill count");

	a_no_msg_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != rdq_pkg::ST_DONE |-> rsp_q.message_out == '0)
		else $error("message on a refused or waiting beat");

endmodule
